// ===== design/ofs_pkg.sv =====
// ----------------------------------------------------------------------------
// OOK frame serializer package
// Shared types, register codes and reset values for the serializer blocks.
// ----------------------------------------------------------------------------
package ofs_pkg;

  // Frame phases, in the order they are sent.
  typedef enum logic [2:0] {
    PhPrefix = 3'd0,
    PhData   = 3'd1,
    PhParity = 3'd2,
    PhSuffix = 3'd3,
    PhGap    = 3'd4,
    PhIdle   = 3'd5
  } ofs_phase_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgPrefix = 2'd0,
    CfgSuffix = 2'd1,
    CfgRepeat = 2'd2,
    CfgGap    = 2'd3
  } ofs_cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  // Register reset values.
  localparam logic [7:0] PrefixRst = 8'hFF;
  localparam logic [7:0] SuffixRst = 8'h01;
  localparam logic [3:0] RepeatRst = 4'd3;
  localparam logic [9:0] GapRst    = 10'd10;
  localparam logic [7:0] HeldRst   = 8'h01;

  typedef struct packed {
    logic [7:0] prefix_byte;
    logic [7:0] suffix_byte;
    logic [3:0] repeat_count;
    logic [9:0] gap_ticks;
  } ofs_cfg_t;

  typedef struct packed {
    logic [7:0] held_byte;
    ofs_phase_e phase;
    logic [2:0] bit_cnt;
    logic [3:0] frames_sent;
    logic [9:0] gap_cnt;
  } ofs_state_t;

  typedef struct packed {
    logic       carrier_on;
    ofs_phase_e phase;
    logic [2:0] bit_index;
    logic [3:0] repeat_index;
  } ofs_result_t;

  localparam ofs_state_t StateRst = '{
    held_byte:   HeldRst,
    phase:       PhPrefix,
    bit_cnt:     3'd0,
    frames_sent: 4'd0,
    gap_cnt:     10'd0
  };

endpackage

// ===== design/ofs_cfg.sv =====
// ----------------------------------------------------------------------------
// OOK frame serializer configuration registers
// Holds prefix, suffix, repeat count and gap length, written by index.
// ----------------------------------------------------------------------------
module ofs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [ofs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ofs_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output ofs_pkg::ofs_cfg_t              cfg_o
);
  import ofs_pkg::*;

  ofs_cfg_t cfg_q, cfg_d;

  // Decode the write transaction into the addressed register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (ofs_cfg_idx_e'(cfg_index_i))
        CfgPrefix: cfg_d.prefix_byte  = cfg_wdata_i[7:0];
        CfgSuffix: cfg_d.suffix_byte  = cfg_wdata_i[7:0];
        CfgRepeat: cfg_d.repeat_count = cfg_wdata_i[3:0];
        CfgGap:    cfg_d.gap_ticks    = cfg_wdata_i[9:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{prefix_byte: PrefixRst, suffix_byte: SuffixRst,
                 repeat_count: RepeatRst, gap_ticks: GapRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/ofs_step.sv =====
// ----------------------------------------------------------------------------
// OOK frame serializer step logic
// Computes the result of one transaction and the next sequencer state.
// ----------------------------------------------------------------------------
module ofs_step (
  input  ofs_pkg::ofs_cfg_t    cfg_i,
  input  ofs_pkg::ofs_state_t  state_i,
  input  logic                 action_i,
  input  logic [7:0]           data_byte_i,
  output ofs_pkg::ofs_state_t  state_o,
  output ofs_pkg::ofs_result_t result_o
);
  import ofs_pkg::*;

  logic [7:0] src_byte;
  logic [3:0] frames_inc;
  logic [9:0] gap_inc;

  // Byte that feeds the carrier in the current byte phase.
  always_comb begin
    case (state_i.phase)
      PhPrefix: src_byte = cfg_i.prefix_byte;
      PhData:   src_byte = state_i.held_byte;
      default:  src_byte = cfg_i.suffix_byte;
    endcase
  end

  assign frames_inc = state_i.frames_sent + 4'd1;
  assign gap_inc    = state_i.gap_cnt + 10'd1;

  // Sequencer: loads restart an idle series, ticks advance one bit.
  always_comb begin
    state_o               = state_i;
    result_o.carrier_on   = 1'b0;
    result_o.phase        = state_i.phase;
    result_o.bit_index    = 3'd0;
    result_o.repeat_index = state_i.frames_sent;

    if (action_i) begin
      state_o.held_byte = data_byte_i;
      if (state_i.phase == PhIdle) begin
        state_o.phase       = PhPrefix;
        state_o.bit_cnt     = 3'd0;
        state_o.frames_sent = 4'd0;
        state_o.gap_cnt     = 10'd0;
      end
      result_o.phase        = state_o.phase;
      result_o.bit_index    = (state_o.phase inside {PhPrefix, PhData, PhSuffix}) ?
                              state_o.bit_cnt : 3'd0;
      result_o.repeat_index = state_o.frames_sent;
    end else begin
      case (state_i.phase)
        PhPrefix, PhData, PhSuffix: begin
          result_o.carrier_on = src_byte[3'd7 - state_i.bit_cnt];
          result_o.bit_index  = state_i.bit_cnt;
          if (state_i.bit_cnt == 3'd7) begin
            state_o.bit_cnt = 3'd0;
            if (state_i.phase == PhSuffix) begin
              // End of frame: count it, then idle, gap or start over.
              state_o.frames_sent = frames_inc;
              state_o.gap_cnt     = 10'd0;
              if (frames_inc >= cfg_i.repeat_count || cfg_i.repeat_count == 4'd0) begin
                state_o.phase = PhIdle;
              end else if (cfg_i.gap_ticks == 10'd0) begin
                state_o.phase = PhPrefix;
              end else begin
                state_o.phase = PhGap;
              end
            end else if (state_i.phase == PhPrefix) begin
              state_o.phase = PhData;
            end else begin
              state_o.phase = PhParity;
            end
          end else begin
            state_o.bit_cnt = state_i.bit_cnt + 3'd1;
          end
        end
        PhParity: begin
          result_o.carrier_on = ^state_i.held_byte;
          state_o.bit_cnt     = 3'd0;
          state_o.phase       = PhSuffix;
        end
        PhGap: begin
          state_o.gap_cnt = gap_inc;
          if (gap_inc >= cfg_i.gap_ticks || gap_inc == 10'd0) begin
            state_o.gap_cnt = 10'd0;
            state_o.bit_cnt = 3'd0;
            state_o.phase   = PhPrefix;
          end
        end
        default: begin
          state_o.phase = PhIdle;
        end
      endcase
    end
  end

endmodule

// ===== design/ook_frame_serializer_top.sv =====
// ----------------------------------------------------------------------------
// OOK frame serializer
// Sends prefix, data, parity and suffix bits as carrier on/off, one per tick.
// ----------------------------------------------------------------------------
// The block accepts one transaction (a bit tick or a data byte load) every
// clock cycle unless the output stalls, and returns exactly one result per
// transaction. The transaction is captured in an input register, and the sequencer
// step runs between that register and the result register. While a result
// waits to be taken, the input register still accepts one more transaction
// and then holds it, so the input stalls only once both registers are full.
// Configuration writes are accepted every cycle and should be issued
// only while no transaction is in flight; they take effect from the next tick.
module ook_frame_serializer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic [7:0]                   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         carrier_on_o,
  output logic [2:0]                   phase_o,
  output logic [2:0]                   bit_index_o,
  output logic [3:0]                   repeat_index_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ofs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ofs_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import ofs_pkg::*;

  ofs_cfg_t    cfg;
  ofs_state_t  state_q, state_d;
  ofs_result_t res_d, res_q;
  logic        in_vld_q, in_vld_d;
  logic        in_action_q;
  logic [7:0]  in_byte_q;
  logic        out_vld_q, out_vld_d;
  logic        in_accept;
  logic        advance;

  ofs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  // Handshake: the input stage moves on whenever the result slot frees up.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_vld_d   = in_accept ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign out_vld_d  = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);

  ofs_step u_step (
    .cfg_i       (cfg),
    .state_i     (state_q),
    .action_i    (in_action_q),
    .data_byte_i (in_byte_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= StateRst;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_action_q <= action_i;
      in_byte_q   <= data_byte_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign carrier_on_o   = res_q.carrier_on;
  assign phase_o        = res_q.phase;
  assign bit_index_o    = res_q.bit_index;
  assign repeat_index_o = res_q.repeat_index;

`ifndef SYNTHESIS
  // The sequencer state only moves when a transaction passes to the result.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("sequencer state changed without a transaction");

  // Gap and idle results never drive the carrier.
  a_quiet_carrier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.phase == PhGap || res_q.phase == PhIdle)) |-> !res_q.carrier_on)
    else $error("carrier driven during gap or idle");

  // Parity, gap and idle results report bit index zero.
  a_bit_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.phase == PhParity || res_q.phase == PhGap ||
                   res_q.phase == PhIdle)) |-> res_q.bit_index == 3'd0)
    else $error("nonzero bit index outside a byte phase");

  // A result is produced only by a transaction held in the input stage.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q))
    else $error("result appeared without a captured transaction");
`endif

endmodule
